// File: hdl/quad_motor_mixer_desaturation_unit_assert.svh
// Assertion macros for the quad motor mixer with desaturation.
// Needs no other file; the modules that assert take it in by include.
`ifndef QUAD_MOTOR_MIXER_DESATURATION_UNIT_ASSERT_SVH
`define QUAD_MOTOR_MIXER_DESATURATION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quad mixer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define QMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quad mixer check failed one cycle later");

`endif

// File: hdl/qmd_pkg.sv
// Package for the quad motor mixer with desaturation: payload types,
// constants and the per-stage arithmetic. Depends on nothing else.
`timescale 1ns / 1ps

package qmd_pkg;

   // Number of desaturation passes by default.
   localparam int PASS_LIMIT_DEFAULT = 10;

   // Widths: commands, mixed values (four commands summed), one extra bit for
   // differences, and the torque scaling product.
   localparam int CW = 24;
   localparam int MW = 26;
   localparam int DW = MW + 1;
   localparam int PW = 32;
   localparam int TW = 12;
   localparam int OW = 16;

   typedef logic signed [CW-1:0] cmd_type;
   typedef logic signed [MW-1:0] mix_type;
   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [TW-1:0] trim_type;
   typedef logic [OW-1:0]        motor_type;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_EN = 3'd4;

   // Limits in Q15.8 counts.
   localparam mix_type  SPAN_LIMIT  = mix_type'(2048 * 256);
   localparam diff_type SPAN_WIDE   = diff_type'(2048 * 256);
   localparam diff_type SHIFT_HIGH  = diff_type'(2038 * 256);
   localparam diff_type MARGIN      = diff_type'(10 * 256);
   localparam mix_type  MIN_SEED    = mix_type'(9999 * 256);
   localparam cmd_type  THR_LOW     = cmd_type'(400 * 256);
   localparam cmd_type  THR_HIGH    = cmd_type'(1600 * 256);
   localparam prod_type SCALE_NUM   = prod_type'(230);
   localparam diff_type S24_MAX     = diff_type'(8388607);
   localparam diff_type S24_MIN     = -diff_type'(8388608);
   localparam diff_type HALF_COUNT  = diff_type'(128);
   localparam diff_type MOTOR_MAX   = diff_type'(65535);

   // One input item.
   typedef struct packed {
      cmd_type thrust_cmd;
      cmd_type roll_cmd;
      cmd_type pitch_cmd;
      cmd_type yaw_cmd;
   } req_type;

   // One result item.
   typedef struct packed {
      motor_type motor0_out;
      motor_type motor1_out;
      motor_type motor2_out;
      motor_type motor3_out;
      logic      in_range;
      cmd_type   thrust_used;
   } rsp_type;

   // Working state of one item as it moves down the passes.
   typedef struct packed {
      cmd_type t;
      cmd_type r;
      cmd_type p;
      cmd_type y;
      mix_type m0;
      mix_type m1;
      mix_type m2;
      mix_type m3;
      mix_type lo;
      mix_type hi;
      logic    ok;
   } pipe_type;

   // Mix the commands into the four X-frame motor values.
   function automatic pipe_type mix_step(pipe_type src);
      pipe_type q;
      mix_type  t;
      mix_type  r;
      mix_type  p;
      mix_type  y;
      q = src;
      t = mix_type'(src.t);
      r = mix_type'(src.r);
      p = mix_type'(src.p);
      y = mix_type'(src.y);
      if (!src.ok) begin
         q.m0 = t - r - p + y;
         q.m1 = t - r + p - y;
         q.m2 = t + r + p + y;
         q.m3 = t + r - p - y;
      end
      return q;
   endfunction

   // Find the minimum and maximum of the mixed values, with their seeds.
   function automatic pipe_type range_step(pipe_type src);
      pipe_type q;
      mix_type  v [4];
      mix_type  lo;
      mix_type  hi;
      q = src;
      v[0] = src.m0;
      v[1] = src.m1;
      v[2] = src.m2;
      v[3] = src.m3;
      lo = MIN_SEED;
      hi = '0;
      for (int i = 0; i < 4; i++) begin
         if (v[i] < lo) begin
            lo = v[i];
         end
         if (v[i] > hi) begin
            hi = v[i];
         end
      end
      if (!src.ok) begin
         q.lo = lo;
         q.hi = hi;
      end
      return q;
   endfunction

   // Scale a torque by 230/256 with floor rounding.
   function automatic cmd_type scale_torque(cmd_type v);
      prod_type prod;
      prod = prod_type'(v) * SCALE_NUM;
      return cmd_type'(prod >>> 8);
   endfunction

   // Accept the pass, or scale the torques, or move the thrust.
   function automatic pipe_type fix_step(pipe_type src);
      pipe_type q;
      diff_type spread;
      diff_type shift;
      diff_type nt;
      q = src;
      spread = diff_type'(src.hi) - diff_type'(src.lo);
      if (src.hi >= SPAN_LIMIT) begin
         shift = diff_type'(src.hi) - SHIFT_HIGH;
      end else begin
         shift = diff_type'(src.lo) - MARGIN;
      end
      nt = diff_type'(src.t) - shift;
      if (!src.ok) begin
         priority if (src.lo >= 0 && src.hi < SPAN_LIMIT) begin
            q.ok = 1'b1;
         end else if (spread >= SPAN_WIDE || (src.t < THR_HIGH && src.t > THR_LOW)) begin
            q.r = scale_torque(src.r);
            q.p = scale_torque(src.p);
            q.y = scale_torque(src.y);
         end else if (nt > S24_MAX) begin
            q.t = cmd_type'(S24_MAX);
         end else if (nt < S24_MIN) begin
            q.t = cmd_type'(S24_MIN);
         end else begin
            q.t = cmd_type'(nt);
         end
      end
      return q;
   endfunction

   // Add the trim, round half up to whole counts and saturate.
   function automatic motor_type to_motor(mix_type m, trim_type trim);
      diff_type sum;
      diff_type c;
      sum = diff_type'(m) + (diff_type'(trim) <<< 8) + HALF_COUNT;
      c = sum >>> 8;
      priority if (c < 0) begin
         return '0;
      end else if (c > MOTOR_MAX) begin
         return '1;
      end else begin
         return c[OW-1:0];
      end
   endfunction

endpackage

// File: hdl/quad_motor_mixer_desaturation_unit.sv
// Quad motor mixer with desaturation, built as a stall-aware pipeline.
// An accepted item passes through every pass stage and then the output register before its result is valid.
// Throughput: one item per cycle while the result is not stalled; each pass is a mix, a min/max and a correction stage.
// A stalled result holds the output register and the run of full stages behind it; empty stages keep filling.
// Reset (synchronous) clears every stage valid bit, the trims and the output enable.
// Depends on qmd_pkg and quad_motor_mixer_desaturation_unit_assert.svh.
`timescale 1ns / 1ps

`include "quad_motor_mixer_desaturation_unit_assert.svh"

module quad_motor_mixer_desaturation_unit #(
   parameter int PASS_LIMIT = qmd_pkg::PASS_LIMIT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qmd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qmd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [qmd_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [qmd_pkg::TW-1:0]            csr_wdata
);

   localparam int NP = 3 * PASS_LIMIT;

   qmd_pkg::trim_type trim_ff [4];
   logic              out_en_ff;

   logic [NP:0]       en;
   logic [NP-1:0]     vld_ff;
   logic [NP-1:0]     src_vld;
   qmd_pkg::pipe_type src_pipe [NP];
   qmd_pkg::pipe_type pipe_in  [NP];
   qmd_pkg::pipe_type pipe_ff  [NP];
   qmd_pkg::pipe_type first_pipe;

   logic              rsp_valid_ff;
   qmd_pkg::rsp_type  rsp_in;
   qmd_pkg::rsp_type  rsp_ff;

   // Configuration registers are written directly; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            trim_ff[i] <= '0;
         end
         out_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx)
            qmd_pkg::REG_TRIM0:  trim_ff[0] <= csr_wdata;
            qmd_pkg::REG_TRIM1:  trim_ff[1] <= csr_wdata;
            qmd_pkg::REG_TRIM2:  trim_ff[2] <= csr_wdata;
            qmd_pkg::REG_TRIM3:  trim_ff[3] <= csr_wdata;
            qmd_pkg::REG_OUT_EN: out_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The incoming item starts with no pass accepted.
   always_comb begin
      first_pipe    = '0;
      first_pipe.t  = req_data.thrust_cmd;
      first_pipe.r  = req_data.roll_cmd;
      first_pipe.p  = req_data.pitch_cmd;
      first_pipe.y  = req_data.yaw_cmd;
      first_pipe.ok = 1'b0;
   end

   // A stage may load when it is empty or when its item moves on.
   assign en[NP]    = !rsp_valid_ff || rsp_ready;
   assign req_ready = en[0];

   generate
      for (genvar g = 0; g < NP; g++) begin : g_stage
         assign en[g] = !vld_ff[g] || en[g+1];

         if (g == 0) begin : g_head
            assign src_pipe[g] = first_pipe;
            assign src_vld[g]  = req_valid;
         end else begin : g_body
            assign src_pipe[g] = pipe_ff[g-1];
            assign src_vld[g]  = vld_ff[g-1];
         end

         // Each pass is mix, then min/max, then accept or correct.
         if ((g % 3) == 0) begin : g_mix
            assign pipe_in[g] = qmd_pkg::mix_step(src_pipe[g]);
         end else if ((g % 3) == 1) begin : g_range
            assign pipe_in[g] = qmd_pkg::range_step(src_pipe[g]);
         end else begin : g_fix
            assign pipe_in[g] = qmd_pkg::fix_step(src_pipe[g]);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (en[g]) begin
               vld_ff[g] <= src_vld[g];
            end
         end

         always_ff @(posedge clock) begin
            if (en[g]) begin
               pipe_ff[g] <= pipe_in[g];
            end
         end
      end
   endgenerate

   // Trim, rounding and saturation form the output register.
   always_comb begin
      rsp_in             = '0;
      rsp_in.in_range    = pipe_ff[NP-1].ok;
      rsp_in.thrust_used = pipe_ff[NP-1].t;
      if (out_en_ff) begin
         rsp_in.motor0_out = qmd_pkg::to_motor(pipe_ff[NP-1].m0, trim_ff[0]);
         rsp_in.motor1_out = qmd_pkg::to_motor(pipe_ff[NP-1].m1, trim_ff[1]);
         rsp_in.motor2_out = qmd_pkg::to_motor(pipe_ff[NP-1].m2, trim_ff[2]);
         rsp_in.motor3_out = qmd_pkg::to_motor(pipe_ff[NP-1].m3, trim_ff[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NP]) begin
         rsp_valid_ff <= vld_ff[NP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NP]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted item always lands in the first stage.
   `QMD_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, vld_ff[0])

   // The input is refused only while the first stage holds an item.
   `QMD_ASSERT_NOW(a_refuse_full, clock, reset, !req_ready, vld_ff[0])

   // Once a pass is accepted, the flag stays set further down.
   `QMD_ASSERT_NEXT(a_ok_sticks, clock, reset, en[1] && vld_ff[0] && pipe_ff[0].ok,
      pipe_ff[1].ok)

   // With the output disabled every motor command is zero.
   `QMD_ASSERT_NEXT(a_disabled_zero, clock, reset, en[NP] && vld_ff[NP-1] && !out_en_ff,
      rsp_ff.motor0_out == '0 && rsp_ff.motor1_out == '0 &&
      rsp_ff.motor2_out == '0 && rsp_ff.motor3_out == '0)

   // The range flag follows the last pass stage into the result.
   `QMD_ASSERT_NEXT(a_range_flag, clock, reset, en[NP] && vld_ff[NP-1],
      rsp_ff.in_range == $past(pipe_ff[NP-1].ok))

endmodule
